// ----- design/assert_macros.svh -----
// Assertion macros used by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/nbe_pkg.sv -----
// Types and constants of the null byte escape encoder.
package nbe_pkg;

  localparam int unsigned SYMBOLS   = 256;
  localparam int unsigned ADDR_W    = $clog2(SYMBOLS);
  localparam int unsigned MAX_EMIT  = 3;

  localparam logic [7:0] COUNT_MAX      = 8'd255;
  localparam logic [7:0] DEFAULT_RARE   = 8'd1;
  localparam logic [7:0] DEFAULT_ESCAPE = 8'd2;
  localparam logic [7:0] CODE_RARE      = 8'd1;
  localparam logic [7:0] CODE_ESCAPE    = 8'd2;
  localparam logic [7:0] NULL_BYTE      = 8'd0;
  localparam logic [7:0] FIRST_SYMBOL   = 8'd1;
  localparam logic [7:0] LAST_SYMBOL    = 8'd255;

  localparam logic CMD_COUNT  = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       final_byte;
  } nbe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } nbe_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CNT_WR,
    S_SCAN,
    S_EMIT
  } nbe_state_t;

endpackage

// ----- design/null_byte_escape_encoder.sv -----
// Top level of the two-pass null byte escape encoder.
//
// Usage: a message is sent twice on the request channel (in_valid, in_stall,
// in_data). In the count pass (cmd = count) each byte goes into a histogram
// held in a 256 x 8 RAM; counts saturate at 255. The final count byte starts
// a walk over entries 1 to 255, twice, that picks the rare marker and then
// the escape marker; both leave on the result channel as a two-byte header.
// In the encode pass (cmd = encode) every byte becomes one or two result
// bytes, and the final one is followed by a zero terminator. out_last marks
// the last result that one request causes.
// A non-final count byte is a RAM read, then the write-back. A final count
// byte also runs the marker walk: two passes of one RAM read per entry.
// An encode byte yields 1 to 3 results. One request is worked on at a time.
// Reset clears the histogram valid bits at once, so no clearing pass is
// needed; the markers return to 1 and 2. The same valid bits are cleared
// again when the final encode byte is accepted.
// When the receiver stalls, the result register holds its value and the
// block waits before loading the next result; a request is taken again
// while the last result of the previous one still waits in that register.

`include "assert_macros.svh"

module null_byte_escape_encoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  nbe_pkg::nbe_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output nbe_pkg::nbe_out_t out_data
);

  // Control state.
  nbe_pkg::nbe_state_t state_r, state_nxt;

  // One valid bit per histogram entry; an entry that is not valid counts zero.
  logic [nbe_pkg::SYMBOLS-1:0] valid_r, valid_nxt;

  // Markers chosen by the last count pass.
  logic [7:0] rare_r, rare_nxt;
  logic [7:0] esc_r, esc_nxt;

  // The request being worked on.
  nbe_pkg::nbe_in_t item_r, item_nxt;

  // Marker walk: read issue counter, compare stage and running minimum.
  logic [7:0] scan_i_r, scan_i_nxt;
  logic       issue_done_r, issue_done_nxt;
  logic       cmp_vld_r, cmp_vld_nxt;
  logic       pass_r, pass_nxt;
  logic [7:0] best_r, best_nxt;

  // Address and valid bit of the entry the RAM is returning this cycle.
  logic [nbe_pkg::ADDR_W-1:0] rd_addr_r;
  logic                       hv_r;

  // Results waiting to be sent for the current request.
  nbe_pkg::nbe_out_t emit_q_r [nbe_pkg::MAX_EMIT];
  nbe_pkg::nbe_out_t emit_q_nxt [nbe_pkg::MAX_EMIT];
  logic [1:0] emit_cnt_r, emit_cnt_nxt;
  logic [1:0] emit_idx_r, emit_idx_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  nbe_pkg::nbe_out_t out_data_r, out_data_nxt;

  // RAM port signals.
  logic                       ram_we;
  logic [nbe_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic [nbe_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  logic [7:0] hist_val;
  logic       in_acc;
  logic       out_free;

  nbe_ram #(
    .WIDTH (8),
    .DEPTH (nbe_pkg::SYMBOLS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != nbe_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Count of the entry read in the previous cycle; an entry that is not valid reads as zero.
  assign hist_val = hv_r ? ram_rdata : 8'd0;

  // The read address follows the walk in the scan state, the incoming byte otherwise.
  assign ram_raddr = (state_r == nbe_pkg::S_SCAN) ? scan_i_r : in_data.data_byte;

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    rare_nxt       = rare_r;
    esc_nxt        = esc_r;
    item_nxt       = item_r;
    scan_i_nxt     = scan_i_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    pass_nxt       = pass_r;
    best_nxt       = best_r;
    emit_q_nxt     = emit_q_r;
    emit_cnt_nxt   = emit_cnt_r;
    emit_idx_nxt   = emit_idx_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = item_r.data_byte;
    ram_wdata      = (hist_val == nbe_pkg::COUNT_MAX) ? nbe_pkg::COUNT_MAX
                                                      : hist_val + 8'd1;

    if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      nbe_pkg::S_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          if (in_data.cmd == nbe_pkg::CMD_COUNT) begin
            state_nxt = nbe_pkg::S_CNT_WR;
          end else begin
            // Build the result list of this encode byte.
            emit_idx_nxt = 2'd0;
            if (in_data.data_byte == rare_r) begin
              emit_q_nxt[0] = '{out_byte: esc_r, out_last: 1'b0};
              emit_q_nxt[1] = '{out_byte: nbe_pkg::CODE_RARE,
                                out_last: !in_data.final_byte};
              emit_cnt_nxt  = 2'd2;
            end else if (in_data.data_byte == esc_r) begin
              emit_q_nxt[0] = '{out_byte: esc_r, out_last: 1'b0};
              emit_q_nxt[1] = '{out_byte: nbe_pkg::CODE_ESCAPE,
                                out_last: !in_data.final_byte};
              emit_cnt_nxt  = 2'd2;
            end else if (in_data.data_byte == nbe_pkg::NULL_BYTE) begin
              emit_q_nxt[0] = '{out_byte: rare_r, out_last: !in_data.final_byte};
              emit_cnt_nxt  = 2'd1;
            end else begin
              emit_q_nxt[0] = '{out_byte: in_data.data_byte,
                                out_last: !in_data.final_byte};
              emit_cnt_nxt  = 2'd1;
            end
            if (in_data.final_byte) begin
              // The terminator follows, and the histogram starts over.
              emit_q_nxt[emit_cnt_nxt] = '{out_byte: nbe_pkg::NULL_BYTE,
                                           out_last: 1'b1};
              emit_cnt_nxt = emit_cnt_nxt + 2'd1;
              valid_nxt    = '0;
            end
            state_nxt = nbe_pkg::S_EMIT;
          end
        end
      end

      nbe_pkg::S_CNT_WR: begin
        // Saturating increment of the entry read in the accept cycle.
        ram_we = 1'b1;
        valid_nxt[item_r.data_byte] = 1'b1;
        if (item_r.final_byte) begin
          scan_i_nxt     = nbe_pkg::FIRST_SYMBOL;
          issue_done_nxt = 1'b0;
          pass_nxt       = 1'b0;
          rare_nxt       = nbe_pkg::DEFAULT_RARE;
          best_nxt       = nbe_pkg::COUNT_MAX;
          state_nxt      = nbe_pkg::S_SCAN;
        end else begin
          state_nxt = nbe_pkg::S_IDLE;
        end
      end

      nbe_pkg::S_SCAN: begin
        // Issue one read per cycle; compare the entry returned from the last.
        if (!issue_done_r) begin
          cmp_vld_nxt = 1'b1;
          if (scan_i_r == nbe_pkg::LAST_SYMBOL) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_i_nxt = scan_i_r + 8'd1;
          end
        end
        if (cmp_vld_r) begin
          if (!pass_r) begin
            if (hist_val < best_r) begin
              rare_nxt = rd_addr_r;
              best_nxt = hist_val;
            end
          end else if (rd_addr_r != rare_r && hist_val < best_r) begin
            esc_nxt  = rd_addr_r;
            best_nxt = hist_val;
          end
        end
        if (issue_done_r && !cmp_vld_r) begin
          if (!pass_r) begin
            // Second walk: least common value other than the rare marker.
            scan_i_nxt     = nbe_pkg::FIRST_SYMBOL;
            issue_done_nxt = 1'b0;
            pass_nxt       = 1'b1;
            best_nxt       = nbe_pkg::COUNT_MAX;
            esc_nxt        = (rare_r == nbe_pkg::DEFAULT_RARE) ? nbe_pkg::DEFAULT_ESCAPE
                                                               : nbe_pkg::DEFAULT_RARE;
          end else begin
            emit_q_nxt[0] = '{out_byte: rare_r, out_last: 1'b0};
            emit_q_nxt[1] = '{out_byte: esc_r, out_last: 1'b1};
            emit_cnt_nxt  = 2'd2;
            emit_idx_nxt  = 2'd0;
            state_nxt     = nbe_pkg::S_EMIT;
          end
        end
      end

      nbe_pkg::S_EMIT: begin
        // Move one result per cycle into the result register when it frees up.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = emit_q_r[emit_idx_r];
          emit_idx_nxt  = emit_idx_r + 2'd1;
          if (emit_idx_nxt == emit_cnt_r) begin
            state_nxt = nbe_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = nbe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nbe_pkg::S_IDLE;
      valid_r      <= '0;
      rare_r       <= nbe_pkg::DEFAULT_RARE;
      esc_r        <= nbe_pkg::DEFAULT_ESCAPE;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      pass_r       <= 1'b0;
      emit_cnt_r   <= 2'd0;
      emit_idx_r   <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      rare_r       <= rare_nxt;
      esc_r        <= esc_nxt;
      issue_done_r <= issue_done_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      pass_r       <= pass_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      emit_idx_r   <= emit_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    scan_i_r   <= scan_i_nxt;
    best_r     <= best_nxt;
    emit_q_r   <= emit_q_nxt;
    out_data_r <= out_data_nxt;
    rd_addr_r  <= ram_raddr;
    hv_r       <= valid_r[ram_raddr];
  end

  // A non-final count byte is written back and the block is free again.
  `ASSERT_NEXT(a_count_two_cycles,
    in_acc && in_data.cmd == nbe_pkg::CMD_COUNT && !in_data.final_byte,
    state_r == nbe_pkg::S_CNT_WR ##1 state_r == nbe_pkg::S_IDLE)

  // The final encode byte leaves an empty histogram behind.
  `ASSERT_NEXT(a_hist_cleared,
    in_acc && in_data.cmd == nbe_pkg::CMD_ENCODE && in_data.final_byte,
    valid_r == '0)

  // Outside the marker walk the two markers always differ.
  `ASSERT_NOW(a_markers_differ,
    state_r != nbe_pkg::S_SCAN,
    rare_r != esc_r)

endmodule

// ----- design/nbe_ram.sv -----
// Generic simple dual-port RAM with a registered read.
module nbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
